// ----- design/axfr_pkg.sv -----
// Shared types and constants for the AX.25 HDLC bit framer.
// No dependencies; every other file of the framer but axfr_checker imports this package.
package axfr_pkg;

	localparam int BYTE_W     = 8;
	localparam int CRC_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Command queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 1'd1;

	localparam logic [CRC_W-1:0] CRC_POLY_RST = 16'h8408;
	localparam logic [CRC_W-1:0] CRC_INIT_RST = 16'hFFFF;

	localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;

	// A zero is stuffed when a one arrives with this many ones already pending.
	localparam logic [2:0] ONES_BEFORE_STUFF = 3'd4;

	// End frame sends CRC low, CRC high and three flags: byte slots 0 to 4.
	localparam logic [2:0] END_LO_BYTE   = 3'd0;
	localparam logic [2:0] END_LAST_BYTE = 3'd4;
	localparam logic [2:0] LAST_BIT_IDX  = 3'd7;

	// Results per item are capped; the result at LAST_RESULT_IDX is then the last one.
	localparam logic [5:0] RESULT_CAP      = 6'd43;
	localparam logic [5:0] LAST_RESULT_IDX = 6'd42;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_FLAG  = 2'd1,
		ACT_DATA  = 2'd2,
		ACT_END   = 2'd3
	} action_t;

	typedef struct packed {
		logic              load_crc;
		logic              end_frame;
		logic              flag;
		logic [BYTE_W-1:0] data;
	} cmd_t;

endpackage

// ----- design/axfr_front.sv -----
// Front part of the framer: accepts input items, decodes the action into a command
// and holds the commands in a short queue for the back part. Depends on axfr_pkg.
module axfr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic [axfr_pkg::BYTE_W-1:0] data_byte,
	output logic                       cmd_valid,
	output axfr_pkg::cmd_t             cmd,
	input  logic                       cmd_pop
);
	import axfr_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cmd_in;
	logic              push;
	logic              pop;

	always_comb begin
		cmd_in = '0;
		cmd_in.data = data_byte;
		case (action_t'(action))
			ACT_START: begin
				cmd_in.load_crc = 1'b1;
				cmd_in.flag = 1'b1;
				cmd_in.data = FLAG_BYTE;
			end
			ACT_FLAG: begin
				cmd_in.flag = 1'b1;
				cmd_in.data = FLAG_BYTE;
			end
			ACT_DATA: begin
				cmd_in.flag = 1'b0;
			end
			ACT_END: begin
				cmd_in.end_frame = 1'b1;
			end
			default: begin
				cmd_in.flag = 1'b0;
			end
		endcase
	end

	assign in_ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- design/axfr_back.sv -----
// Back part of the framer: serializes each command bit by bit with CRC update,
// zero stuffing and NRZI coding, and drives the output register. Depends on axfr_pkg.
module axfr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  axfr_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	input  logic                          cfg_write,
	input  logic [axfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [axfr_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_bit,
	output logic                          last_bit
);
	import axfr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_BIT   = 3'b010,
		ST_STUFF = 3'b100
	} bk_state_t;

	bk_state_t         state_q, state_n;
	logic [CRC_W-1:0]  crc_poly_q;
	logic [CRC_W-1:0]  crc_init_q;
	logic [CRC_W-1:0]  crc_q, crc_bit, crc_d;
	logic              tone_q, tone_bit, tone_d;
	logic [2:0]        ones_q, ones_d;
	logic [BYTE_W-1:0] cur_byte_q, cur_byte_n;
	logic [BYTE_W-1:0] hi_byte_q, hi_byte_n;
	logic              flag_q, flag_n;
	logic              end_q, end_n;
	logic [2:0]        byte_idx_q, byte_idx_n;
	logic [2:0]        bit_idx_q, bit_idx_n;
	logic [5:0]        res_cnt_q, res_cnt_n;
	logic              out_valid_q;
	logic              line_bit_q;
	logic              last_bit_q;

	logic adv, cur_bit, stuff_now, bit_done, byte_done, last_byte, item_done;
	logic load, emit, emit_val, emit_last;

	always_comb begin
		adv       = (state_q != ST_IDLE) && (!out_valid_q || out_ready);
		cur_bit   = cur_byte_q[bit_idx_q];
		stuff_now = (state_q == ST_BIT) && !flag_q && cur_bit
			&& (ones_q == ONES_BEFORE_STUFF);
		bit_done  = (state_q == ST_STUFF) || ((state_q == ST_BIT) && !stuff_now);
		byte_done = bit_done && (bit_idx_q == LAST_BIT_IDX);
		last_byte = !end_q || (byte_idx_q == END_LAST_BYTE);
		item_done = adv && byte_done && last_byte;
		load      = cmd_valid && ((state_q == ST_IDLE) || item_done);
		emit      = adv && (res_cnt_q < RESULT_CAP);
		emit_last = (byte_done && last_byte) || (res_cnt_q == LAST_RESULT_IDX);
		emit_val  = (state_q == ST_BIT) ? (cur_bit ? tone_q : ~tone_q) : ~tone_q;
	end

	assign cmd_pop = load;

	// Per-bit datapath: CRC, ones count and line tone.
	always_comb begin
		crc_bit  = crc_q;
		tone_bit = tone_q;
		ones_d   = ones_q;
		if (adv) begin
			case (state_q)
				ST_BIT: begin
					if (!flag_q) begin
						crc_bit = (crc_q >> 1) ^ (((crc_q[0] ^ cur_bit)) ? crc_poly_q : '0);
					end
					if (cur_bit) begin
						ones_d = flag_q ? 3'd1 : ones_q + 3'd1;
					end else begin
						ones_d   = '0;
						tone_bit = ~tone_q;
					end
				end
				ST_STUFF: begin
					ones_d   = '0;
					tone_bit = ~tone_q;
				end
				default: begin
					ones_d = ones_q;
				end
			endcase
		end
		crc_d  = (load && cmd.load_crc) ? crc_init_q : crc_bit;
		tone_d = (load && cmd.load_crc) ? 1'b1 : tone_bit;
	end

	// Byte and bit sequencer.
	always_comb begin
		state_n    = state_q;
		cur_byte_n = cur_byte_q;
		hi_byte_n  = hi_byte_q;
		flag_n     = flag_q;
		end_n      = end_q;
		byte_idx_n = byte_idx_q;
		bit_idx_n  = bit_idx_q;
		res_cnt_n  = res_cnt_q;
		if (adv) begin
			res_cnt_n = res_cnt_q + 6'd1;
			if (stuff_now) begin
				state_n = ST_STUFF;
			end else begin
				state_n   = ST_BIT;
				bit_idx_n = bit_idx_q + 3'd1;
				if (byte_done && !last_byte) begin
					byte_idx_n = byte_idx_q + 3'd1;
					cur_byte_n = (byte_idx_q == END_LO_BYTE) ? hi_byte_q : FLAG_BYTE;
					flag_n     = (byte_idx_q != END_LO_BYTE);
				end
				if (item_done) begin
					state_n = ST_IDLE;
				end
			end
		end
		if (load) begin
			state_n    = ST_BIT;
			bit_idx_n  = '0;
			byte_idx_n = '0;
			res_cnt_n  = '0;
			flag_n     = cmd.flag;
			end_n      = cmd.end_frame;
			// The CRC is taken after the bit finishing this cycle has been fed in.
			cur_byte_n = cmd.end_frame ? ~crc_bit[BYTE_W-1:0] : cmd.data;
			hi_byte_n  = ~crc_bit[CRC_W-1:BYTE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= CRC_POLY_RST;
			crc_init_q <= CRC_INIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CRC_POLY: crc_poly_q <= cfg_data;
				REG_CRC_INIT: crc_init_q <= cfg_data;
				default: begin
					crc_poly_q <= crc_poly_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			crc_q       <= CRC_INIT_RST;
			tone_q      <= 1'b1;
			ones_q      <= '0;
			byte_idx_q  <= '0;
			bit_idx_q   <= '0;
			res_cnt_q   <= '0;
			end_q       <= 1'b0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_n;
			crc_q      <= crc_d;
			tone_q     <= tone_d;
			ones_q     <= ones_d;
			byte_idx_q <= byte_idx_n;
			bit_idx_q  <= bit_idx_n;
			res_cnt_q  <= res_cnt_n;
			end_q      <= end_n;
			flag_q     <= flag_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_byte_q <= cur_byte_n;
		hi_byte_q  <= hi_byte_n;
		if (emit) begin
			line_bit_q <= emit_val;
			last_bit_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign line_bit  = line_bit_q;
	assign last_bit  = last_bit_q;

endmodule

// ----- design/ax25_hdlc_bit_framer_core.sv -----
// Top level of the AX.25 HDLC bit framer: front decoder and queue, back serializer.
// Depends on axfr_pkg, axfr_front and axfr_back.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    action, data_byte
//   output    out_valid / out_ready  line_bit, last_bit
//   config    cfg_write              cfg_index, cfg_data
//
// The serializer sends one line bit per cycle while the output is not stalled;
// a queued next item is loaded in the same cycle as the last bit of the one
// before is serialized.
// Reset clears the queue, the serializer and the output valid flag; the CRC
// register, polynomial and initial value take their reset values.
// A stalled output transfer holds the serializer; the two-entry queue keeps
// accepting input until it is full.
module ax25_hdlc_bit_framer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      action,
	input  logic [axfr_pkg::BYTE_W-1:0]     data_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            line_bit,
	output logic                            last_bit,
	input  logic                            cfg_write,
	input  logic [axfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [axfr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import axfr_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	axfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.data_byte (data_byte),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	axfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.line_bit  (line_bit),
		.last_bit  (last_bit)
	);

endmodule

// ----- design/axfr_checker.sv -----
// Port-level checks for the AX.25 HDLC bit framer, bound to the top level.
// Depends only on the port names of ax25_hdlc_bit_framer_core.
module axfr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic line_bit,
	input logic last_bit
);
	// Items accepted whose final line bit has not yet been transferred.
	logic [2:0] open_q;
	logic       in_xfer;
	logic       end_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign end_xfer = out_valid && out_ready && last_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_xfer && !end_xfer) begin
			open_q <= open_q + 3'd1;
		end else if (end_xfer && !in_xfer) begin
			open_q <= open_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_bit) && $stable(last_bit))
		else $error("output payload changed while stalled");

	a_last_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		end_xfer |-> open_q != 3'd0)
		else $error("final line bit transferred with no item open");

	a_full_means_two: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> open_q >= 3'd2)
		else $error("input stalled with fewer than two items open");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd4)
		else $error("more items open than the queue and serializer can hold");

endmodule

bind ax25_hdlc_bit_framer_core axfr_checker u_axfr_checker (.*);

// ----- sim/ax25_hdlc_line_checker.sv -----
// Line-bit checker for the AX.25 HDLC bit framer: watches the input, output and
// register ports, predicts the NRZI line bits of each transfer and compares them.
// Depends on axfr_pkg for widths, register indexes, actions and the flag value.
module ax25_hdlc_line_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [1:0]                      action,
	input  logic [axfr_pkg::BYTE_W-1:0]     data_byte,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            line_bit,
	input  logic                            last_bit,
	input  logic                            cfg_write,
	input  logic [axfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [axfr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              bits_pending,
	output int                              bits_checked
);
	import axfr_pkg::*;

	localparam logic [2:0] STUFF_RUN   = 3'd5;
	localparam int         REPORT_MAX  = 10;
	localparam int         END_FLAGS   = 3;

	typedef struct packed {
		logic level;
		logic is_last;
	} line_res_t;

	logic [CRC_W-1:0] crc_poly_cfg;
	logic [CRC_W-1:0] crc_init_cfg;
	logic [CRC_W-1:0] crc_acc;
	logic             tone;
	logic [2:0]       ones_pending;
	logic             tone_seq[$];
	line_res_t        bits_due[$];

	// Serializes one byte LSB first, with stuffing and CRC update unless it is a flag.
	function automatic void serialize_byte(input logic [BYTE_W-1:0] value, input logic is_flag);
		int   k;
		logic b;
		logic fb;
		for (k = 0; k < BYTE_W; k++) begin
			b = value[k];
			if (is_flag) begin
				ones_pending = '0;
			end else begin
				fb = crc_acc[0] ^ b;
				crc_acc = crc_acc >> 1;
				if (fb)
					crc_acc = crc_acc ^ crc_poly_cfg;
			end
			if (b) begin
				ones_pending = ones_pending + 3'd1;
				if (ones_pending == STUFF_RUN) begin
					// The one goes out first, then the stuffed zero toggles the tone.
					tone_seq.push_back(tone);
					tone = ~tone;
					ones_pending = '0;
				end
			end else begin
				ones_pending = '0;
				tone = ~tone;
			end
			tone_seq.push_back(tone);
		end
	endfunction

	function automatic void predict_item(input action_t act, input logic [BYTE_W-1:0] data_in);
		logic [BYTE_W-1:0] crc_lo;
		logic [BYTE_W-1:0] crc_hi;
		int                n;
		int                i;
		tone_seq.delete();
		case (act)
			ACT_START: begin
				crc_acc = crc_init_cfg;
				tone = 1'b1;
				serialize_byte(FLAG_BYTE, 1'b1);
			end
			ACT_FLAG: serialize_byte(FLAG_BYTE, 1'b1);
			ACT_DATA: serialize_byte(data_in, 1'b0);
			default: begin
				// Both CRC bytes are captured before the CRC moves on over them.
				crc_lo = ~crc_acc[7:0];
				crc_hi = ~crc_acc[15:8];
				serialize_byte(crc_lo, 1'b0);
				serialize_byte(crc_hi, 1'b0);
				for (i = 0; i < END_FLAGS; i++)
					serialize_byte(FLAG_BYTE, 1'b1);
			end
		endcase
		n = (tone_seq.size() > int'(RESULT_CAP)) ? int'(RESULT_CAP) : tone_seq.size();
		for (i = 0; i < n; i++)
			bits_due.push_back('{level: tone_seq[i], is_last: (i == n - 1)});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_res_t exp_bit;
		if (!arst_n) begin
			crc_poly_cfg = CRC_POLY_RST;
			crc_init_cfg = CRC_INIT_RST;
			crc_acc      = '1;
			tone         = 1'b1;
			ones_pending = '0;
			bits_due.delete();
			mismatches   = 0;
			bits_checked = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_CRC_POLY)
					crc_poly_cfg = cfg_data;
				else if (cfg_index == REG_CRC_INIT)
					crc_init_cfg = cfg_data;
			end
			// Output first: a bit leaving now cannot belong to an item arriving now.
			if (out_valid && out_ready) begin
				if (bits_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected line bit: level %b last %b", line_bit, last_bit);
				end else begin
					exp_bit = bits_due.pop_front();
					if (line_bit !== exp_bit.level || last_bit !== exp_bit.is_last) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("line bit %0d: expected level %b last %b, got level %b last %b",
								bits_checked, exp_bit.level, exp_bit.is_last, line_bit, last_bit);
					end
				end
				bits_checked++;
			end
			if (in_valid && in_ready)
				predict_item(action_t'(action), data_byte);
		end
		bits_pending = bits_due.size();
	end

endmodule

// ----- sim/tb_ax25_hdlc_bit_framer_core.sv -----
// Testbench top for ax25_hdlc_bit_framer_core: clock, reset, frame stimulus,
// register settings and verdict. Depends on axfr_pkg and ax25_hdlc_line_checker.
module tb_ax25_hdlc_bit_framer_core;
	import axfr_pkg::*;

	localparam int RANDOM_PER_PHASE = 49;
	localparam int PHASES           = 6;
	localparam int IDLE_PCT         = 17;
	localparam int SETTLE_CYCLES    = 4;
	localparam int END_TAIL         = 20;
	localparam int QUIET_LIMIT      = 2000;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [1:0]            action     = ACT_FLAG;
	logic [BYTE_W-1:0]     data_byte  = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic                  line_bit;
	logic                  last_bit;
	logic                  cfg_write  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = REG_CRC_POLY;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	int   mismatches;
	int   bits_pending;
	int   bits_checked;
	int   items_sent   = 0;
	int   settings     = 0;
	int   quiet_cycles = 0;
	logic steady       = 1'b0;

	ax25_hdlc_bit_framer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.line_bit  (line_bit),
		.last_bit  (last_bit),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ax25_hdlc_line_checker u_line_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_bit     (line_bit),
		.last_bit     (last_bit),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.bits_pending (bits_pending),
		.bits_checked (bits_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input action_t act, input logic [BYTE_W-1:0] value);
		int gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		data_byte <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Waits until every predicted line bit has been transferred.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bits_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_crc(input logic [CRC_W-1:0] poly, input logic [CRC_W-1:0] init);
		cfg_write <= 1'b1;
		cfg_index <= REG_CRC_POLY;
		cfg_data  <= poly;
		@(posedge clk);
		cfg_index <= REG_CRC_INIT;
		cfg_data  <= init;
		@(posedge clk);
		cfg_write <= 1'b0;
		settings++;
	endtask

	// Frame content leans toward long runs of ones so that stuffing is frequent.
	function automatic logic [BYTE_W-1:0] pick_data();
		case ($urandom_range(7))
			0:       return 8'hFF;
			1:       return FLAG_BYTE;
			2:       return 8'($urandom_range(255)) | 8'hF0;
			3:       return 8'($urandom_range(255)) | 8'h0F;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic random_frame();
		int n_data;
		int i;
		n_data = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
		send_item(ACT_START, 8'($urandom));
		repeat ($urandom_range(2)) send_item(ACT_FLAG, 8'($urandom));
		for (i = 0; i < n_data; i++)
			send_item(ACT_DATA, pick_data());
		send_item(ACT_END, 8'($urandom));
		repeat ($urandom_range(1)) send_item(ACT_FLAG, 8'($urandom));
	endtask

	initial begin
		int ph;
		int directed_n;
		logic [CRC_W-1:0] poly;
		logic [CRC_W-1:0] init;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: data and end frame before any start, then all byte shapes.
		send_item(ACT_DATA, 8'hFF);
		send_item(ACT_DATA, 8'h00);
		send_item(ACT_END, 8'h00);
		send_item(ACT_START, 8'hFF);
		send_item(ACT_FLAG, 8'h00);
		send_item(ACT_DATA, 8'h00);
		send_item(ACT_DATA, 8'hFF);
		send_item(ACT_DATA, FLAG_BYTE);
		send_item(ACT_DATA, 8'hAA);
		send_item(ACT_DATA, 8'h55);
		send_item(ACT_DATA, 8'h0F);
		send_item(ACT_DATA, 8'hF0);
		send_item(ACT_DATA, 8'h3E);
		send_item(ACT_END, 8'hFF);
		send_item(ACT_END, 8'h7E);

		// A zero polynomial and start value keep the CRC at zero, so an end frame
		// after four pending ones runs past the result cap.
		settle();
		set_crc(16'h0000, 16'h0000);
		send_item(ACT_START, 8'h00);
		send_item(ACT_DATA, 8'hF0);
		send_item(ACT_END, 8'h00);
		send_item(ACT_DATA, 8'hF0);
		send_item(ACT_END, 8'hFF);
		send_item(ACT_FLAG, 8'hFF);
		send_item(ACT_START, 8'h00);
		send_item(ACT_DATA, 8'hFF);
		send_item(ACT_END, 8'h00);
		directed_n = items_sent;

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       begin poly = CRC_POLY_RST;  init = CRC_INIT_RST; end
				1:       begin poly = 16'hFFFF;      init = 16'hFFFF;     end
				2:       begin poly = 16'h0000;      init = 16'h0000;     end
				3:       begin poly = 16'h1021;      init = 16'($urandom); end
				4:       begin poly = 16'($urandom); init = 16'($urandom); end
				default: begin poly = CRC_POLY_RST;  init = 16'h0000;     end
			endcase
			settle();
			set_crc(poly, init);
			steady = (ph == 1);
			while (items_sent < directed_n + (ph + 1) * RANDOM_PER_PHASE) begin
				if ($urandom_range(99) < 15)
					send_item(action_t'($urandom_range(3)), 8'($urandom));
				else
					random_frame();
			end
		end
		steady = 1'b0;

		settle();
		repeat (END_TAIL) @(posedge clk);
		$display("Sent %0d items (frames, stray flags and noise) under %0d CRC settings.",
			items_sent, settings + 1);
		$display("Compared %0d line bits, including capped end frames.", bits_checked);
		if (mismatches == 0 && bits_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
